### src/i2r_pkg.sv
// shared types, letter codes and digit pattern functions for the roman numeral encoder
package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 8;
    localparam int MAX_VALUE = 3999;

    localparam logic [LETTER_W-1:0] CHAR_M = 8'h4D;
    localparam logic [LETTER_W-1:0] CHAR_D = 8'h44;
    localparam logic [LETTER_W-1:0] CHAR_C = 8'h43;
    localparam logic [LETTER_W-1:0] CHAR_L = 8'h4C;
    localparam logic [LETTER_W-1:0] CHAR_X = 8'h58;
    localparam logic [LETTER_W-1:0] CHAR_V = 8'h56;
    localparam logic [LETTER_W-1:0] CHAR_I = 8'h49;
    localparam logic [LETTER_W-1:0] CHAR_NONE = 8'h00;

    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } sym_t;

    typedef enum logic [1:0] {
        POS_UNITS,
        POS_TENS,
        POS_HUNDREDS,
        POS_THOUSANDS
    } pos_t;

    // number of letters a decimal digit expands to
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        unique case (d) inside
            4'd1, 4'd5:        n = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:              n = 3'd2;
            4'd3, 4'd7:        n = 3'd3;
            4'd8:              n = 3'd4;
            default:           n = 3'd0;
        endcase
        return n;
    endfunction

    // symbol at a given step of a digit's pattern
    function automatic sym_t digit_sym(input logic [3:0] d, input logic [1:0] step);
        sym_t s;
        s = SYM_ONE;
        unique case (d) inside
            4'd4:         s = (step == 2'd0) ? SYM_ONE : SYM_FIVE;
            4'd5, 4'd6,
            4'd7, 4'd8:   s = (step == 2'd0) ? SYM_FIVE : SYM_ONE;
            4'd9:         s = (step == 2'd0) ? SYM_ONE : SYM_TEN;
            default:      s = SYM_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [LETTER_W-1:0] pos_letter(input pos_t pos, input sym_t s);
        logic [LETTER_W-1:0] c;
        c = CHAR_M;
        unique case (pos)
            POS_UNITS:     c = (s == SYM_ONE) ? CHAR_I : (s == SYM_FIVE) ? CHAR_V : CHAR_X;
            POS_TENS:      c = (s == SYM_ONE) ? CHAR_X : (s == SYM_FIVE) ? CHAR_L : CHAR_C;
            POS_HUNDREDS:  c = (s == SYM_ONE) ? CHAR_C : (s == SYM_FIVE) ? CHAR_D : CHAR_M;
            POS_THOUSANDS: c = CHAR_M;
            default:       c = CHAR_M;
        endcase
        return c;
    endfunction

    // index of the highest set bit of a four bit mask
    function automatic pos_t highest_pos(input logic [3:0] m);
        pos_t p;
        if (m[3])      p = POS_THOUSANDS;
        else if (m[2]) p = POS_HUNDREDS;
        else if (m[1]) p = POS_TENS;
        else           p = POS_UNITS;
        return p;
    endfunction

    typedef struct packed {
        logic [1:0] d3;
        logic [9:0] rem;
        logic       err;
    } s2_t;

    typedef struct packed {
        logic [1:0] d3;
        logic [3:0] d2;
        logic [6:0] rem;
        logic       err;
    } s3_t;

    typedef struct packed {
        logic [1:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
        logic       err;
    } s4_t;

endpackage

### src/integer_to_roman_encoder.sv
// integer to roman numeral encoder: digit split pipeline and letter serializer
// a value passes stages 1 to 4 and the serializer before its first letter shows
// throughput: a new value can enter every cycle while in_ready is high;
//   letters leave one per cycle while taken, 1 to 15 per numeral, 1 on error
// the output serializer sets the sustained rate; the digit stages absorb stalls
// reset clears all valid bits; data registers are not reset
module integer_to_roman_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [i2r_pkg::VALUE_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [i2r_pkg::LETTER_W-1:0]   letter,
    output logic                           last,
    output logic                           error
);

    // stage valid bits
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic ser_valid_reg, ser_valid_next;

    // stage payloads
    logic [i2r_pkg::VALUE_W-1:0] s1_value_reg;
    i2r_pkg::s2_t s2_reg, s2_next;
    i2r_pkg::s3_t s3_reg, s3_next;
    i2r_pkg::s4_t s4_reg, s4_next;

    // serializer state
    logic [3:0]    digit_reg [4];
    logic [3:0]    mask_reg;
    logic          err_reg;
    i2r_pkg::pos_t pos_reg, pos_next;
    logic [1:0]    step_reg, step_next;

    logic en1, en2, en3, en4;
    logic ser_free, ser_load, ser_take, ser_last, more_in_digit;
    logic [3:0] cur_digit;
    logic [3:0] lower_mask;
    logic [3:0] s4_mask;

    // stage 2: thousands digit
    always_comb
    begin
        s2_next.err = (s1_value_reg == '0) ||
                      (s1_value_reg > i2r_pkg::VALUE_W'(i2r_pkg::MAX_VALUE));
        if (s1_value_reg >= 12'd3000)
        begin
            s2_next.d3  = 2'd3;
            s2_next.rem = 10'(s1_value_reg - 12'd3000);
        end
        else if (s1_value_reg >= 12'd2000)
        begin
            s2_next.d3  = 2'd2;
            s2_next.rem = 10'(s1_value_reg - 12'd2000);
        end
        else if (s1_value_reg >= 12'd1000)
        begin
            s2_next.d3  = 2'd1;
            s2_next.rem = 10'(s1_value_reg - 12'd1000);
        end
        else
        begin
            s2_next.d3  = 2'd0;
            s2_next.rem = s1_value_reg[9:0];
        end
    end

    // stage 3: hundreds digit by parallel compares
    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s2_reg.rem >= 10'(k * 100))
                d = 4'(k);
        end
        s3_next.d3  = s2_reg.d3;
        s3_next.d2  = d;
        s3_next.rem = 7'(s2_reg.rem - 10'(d) * 10'd100);
        s3_next.err = s2_reg.err;
    end

    // stage 4: tens and units digits
    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s3_reg.rem >= 7'(k * 10))
                d = 4'(k);
        end
        s4_next.d3  = s3_reg.d3;
        s4_next.d2  = s3_reg.d2;
        s4_next.d1  = d;
        s4_next.d0  = 4'(s3_reg.rem - 7'(d) * 7'd10);
        s4_next.err = s3_reg.err;
    end

    // serializer decode
    always_comb
    begin
        cur_digit     = digit_reg[pos_reg];
        more_in_digit = ({1'b0, step_reg} + 3'd1) < i2r_pkg::digit_len(cur_digit);
        lower_mask    = mask_reg & ((4'd1 << pos_reg) - 4'd1);
        ser_last      = err_reg || (!more_in_digit && (lower_mask == 4'd0));
    end

    assign s4_mask = {s4_reg.d3 != 2'd0, s4_reg.d2 != 4'd0,
                      s4_reg.d1 != 4'd0, s4_reg.d0 != 4'd0};

    // handshake and stall chain
    assign ser_take = ser_valid_reg && out_ready;
    assign ser_free = !ser_valid_reg || (out_ready && ser_last);
    assign ser_load = s4_valid_reg && ser_free;
    assign en4      = !s4_valid_reg || ser_free;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        s1_valid_next  = en1 ? in_valid     : s1_valid_reg;
        s2_valid_next  = en2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = en3 ? s2_valid_reg : s3_valid_reg;
        s4_valid_next  = en4 ? s3_valid_reg : s4_valid_reg;
        ser_valid_next = ser_load ? 1'b1 : ((ser_take && ser_last) ? 1'b0 : ser_valid_reg);
    end

    // next letter position: stay in digit, else drop to next nonzero digit below
    always_comb
    begin
        pos_next  = pos_reg;
        step_next = step_reg;
        if (ser_load)
        begin
            pos_next  = i2r_pkg::highest_pos(s4_mask);
            step_next = 2'd0;
        end
        else if (ser_take && !ser_last)
        begin
            if (more_in_digit)
                step_next = step_reg + 2'd1;
            else
            begin
                pos_next  = i2r_pkg::highest_pos(lower_mask);
                step_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            ser_valid_reg <= ser_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_value_reg <= value;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
        if (en4)
            s4_reg <= s4_next;
        if (ser_load)
        begin
            digit_reg[3] <= {2'b00, s4_reg.d3};
            digit_reg[2] <= s4_reg.d2;
            digit_reg[1] <= s4_reg.d1;
            digit_reg[0] <= s4_reg.d0;
            mask_reg     <= s4_mask;
            err_reg      <= s4_reg.err;
        end
        pos_reg  <= pos_next;
        step_reg <= step_next;
    end

    assign out_valid = ser_valid_reg;
    assign last      = ser_last;
    assign error     = err_reg;
    assign letter    = err_reg ? i2r_pkg::CHAR_NONE
                     : i2r_pkg::pos_letter(pos_reg, i2r_pkg::digit_sym(cur_digit, step_reg));

    // an error transaction is a single marked item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (last && letter == i2r_pkg::CHAR_NONE))
        else $error("error item not a single empty last item");

    // a valid numeral letter is never empty
    a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !error) |-> (letter != i2r_pkg::CHAR_NONE))
        else $error("empty letter in numeral");

    // an empty front stage always takes input
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("front stage empty but input stalled");

    // a non-final letter taken keeps the serializer busy
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("numeral run ended before last letter");

endmodule

### tb/integer_to_roman_encoder_tb.sv
// testbench for the integer to roman numeral encoder with a scoreboard and random handshakes
`timescale 1ns / 100ps

module integer_to_roman_encoder_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [i2r_pkg::LETTER_W-1:0] ch;
        logic                         last;
        logic                         err;
    } roman_letter_t;

    class roman_scoreboard;
        roman_letter_t pending_letters[$];
        int mismatches;
        int letters_checked;
        int values_taken;
        int out_of_range;

        function new();
            mismatches = 0;
            letters_checked = 0;
            values_taken = 0;
            out_of_range = 0;
        endfunction

        function int pending();
            return pending_letters.size();
        endfunction

        // expand one accepted value into the run of letters it should produce
        function void add_numeral(input logic [i2r_pkg::VALUE_W-1:0] v);
            logic [i2r_pkg::LETTER_W-1:0] chars[$];
            int dgt[4];
            int n;
            int p;
            int k;
            logic [i2r_pkg::LETTER_W-1:0] one_c;
            logic [i2r_pkg::LETTER_W-1:0] five_c;
            logic [i2r_pkg::LETTER_W-1:0] ten_c;
            roman_letter_t item;
            values_taken++;
            if (v == 0 || v > i2r_pkg::MAX_VALUE)
            begin
                out_of_range++;
                item.ch = i2r_pkg::CHAR_NONE;
                item.last = 1'b1;
                item.err = 1'b1;
                pending_letters.push_back(item);
                return;
            end
            n = int'(v);
            dgt[3] = n / 1000;
            dgt[2] = (n / 100) % 10;
            dgt[1] = (n / 10) % 10;
            dgt[0] = n % 10;
            for (p = 3; p >= 0; p--)
            begin
                case (p)
                    3:
                    begin
                        one_c = i2r_pkg::CHAR_M;
                        five_c = i2r_pkg::CHAR_NONE;
                        ten_c = i2r_pkg::CHAR_NONE;
                    end
                    2:
                    begin
                        one_c = i2r_pkg::CHAR_C;
                        five_c = i2r_pkg::CHAR_D;
                        ten_c = i2r_pkg::CHAR_M;
                    end
                    1:
                    begin
                        one_c = i2r_pkg::CHAR_X;
                        five_c = i2r_pkg::CHAR_L;
                        ten_c = i2r_pkg::CHAR_C;
                    end
                    default:
                    begin
                        one_c = i2r_pkg::CHAR_I;
                        five_c = i2r_pkg::CHAR_V;
                        ten_c = i2r_pkg::CHAR_X;
                    end
                endcase
                case (dgt[p])
                    4:
                    begin
                        chars.push_back(one_c);
                        chars.push_back(five_c);
                    end
                    9:
                    begin
                        chars.push_back(one_c);
                        chars.push_back(ten_c);
                    end
                    default:
                    begin
                        // zero digit falls through here and adds nothing
                        if (dgt[p] >= 5)
                            chars.push_back(five_c);
                        for (k = 0; k < dgt[p] % 5; k++)
                            chars.push_back(one_c);
                    end
                endcase
            end
            foreach (chars[i])
            begin
                item.ch = chars[i];
                item.last = (i == chars.size() - 1);
                item.err = 1'b0;
                pending_letters.push_back(item);
            end
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            if (mismatches < 50)
                $display("mismatch: %s got %0h expected %0h", what, got, want);
            mismatches++;
        endtask

        task check_letter(input logic [i2r_pkg::LETTER_W-1:0] l, input logic la,
                          input logic er);
            roman_letter_t want;
            if (pending_letters.size() == 0)
            begin
                report_mismatch("letter with nothing pending", l, 0);
                return;
            end
            want = pending_letters.pop_front();
            letters_checked++;
            if (l !== want.ch)
                report_mismatch("letter", l, want.ch);
            if (la !== want.last)
                report_mismatch("last", la, want.last);
            if (er !== want.err)
                report_mismatch("error", er, want.err);
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [i2r_pkg::VALUE_W-1:0]  value;
    logic                         out_valid;
    logic                         out_ready;
    logic [i2r_pkg::LETTER_W-1:0] letter;
    logic                         last;
    logic                         error;

    roman_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;

    integer_to_roman_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .letter    (letter),
        .last      (last),
        .error     (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d letters still pending", cycles, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    // result side: check every letter transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_letter(letter, last, error);
    end

    // receiver: random stall bursts, one long hold on request, always ready once calm
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_value(input logic [i2r_pkg::VALUE_W-1:0] v);
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.add_numeral(v);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain_numerals();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [i2r_pkg::VALUE_W-1:0] pick_value();
        logic [i2r_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = ($urandom_range(0, 3) == 0) ? '0
                         : i2r_pkg::VALUE_W'($urandom_range(4000, 4095));
            1:       v = i2r_pkg::VALUE_W'($urandom_range(1, 20));
            2:       v = i2r_pkg::VALUE_W'($urandom_range(3000, 3999));
            default: v = i2r_pkg::VALUE_W'($urandom_range(1, 3999));
        endcase
        return v;
    endfunction

    initial
    begin
        logic [i2r_pkg::VALUE_W-1:0] directed[$];
        directed = '{12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000, 12'd4095, 12'd4,
                     12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd50, 12'd500,
                     12'd1000, 12'd3000, 12'd1994, 12'd2049, 12'd1005, 12'd3090,
                     12'd444, 12'd999, 12'd2048, 12'd1365, 12'd2730};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_value(directed[i]);
            maybe_gap();
        end

        repeat (30)
        begin
            send_value(pick_value());
            maybe_gap();
        end

        // hold the output while long numerals keep coming so the input backs up
        hold_req = 1'b1;
        repeat (12)
            send_value(i2r_pkg::VALUE_W'($urandom_range(2300, 3899)));
        drain_numerals();

        repeat (25)
        begin
            send_value(pick_value());
            maybe_gap();
        end

        calm = 1'b1;
        repeat (28)
            send_value(pick_value());

        drain_numerals();
        repeat (20) @(posedge clk);

        $display("encoded %0d values (%0d out of range) into %0d checked letter transactions",
                 sb.values_taken, sb.out_of_range, sb.letters_checked);
        $display("covered digit extremes, subtractive forms, random stalls and a full backup");
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/i2r_pkg.sv
src/integer_to_roman_encoder.sv
tb/integer_to_roman_encoder_tb.sv
